/* src/cbd_pkg.sv */
// Shared types, address constants and the address decoder of the processor bus decoder.
package cbd_pkg;

  // Item command codes.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  // Bus target codes.
  typedef enum logic [2:0] {
    TGT_RAM  = 3'd0,
    TGT_PIC  = 3'd1,
    TGT_SND  = 3'd2,
    TGT_PAD  = 3'd3,
    TGT_CART = 3'd4,
    TGT_NONE = 3'd5,
    TGT_DMA  = 3'd6
  } target_t;

  // Forwarding codes.
  typedef enum logic [1:0] {
    FWD_NONE  = 2'd0,
    FWD_READ  = 2'd1,
    FWD_WRITE = 2'd2
  } fwd_t;

  localparam logic [15:0] ADDR_PIC_BASE  = 16'h2000;
  localparam logic [15:0] ADDR_SND_BASE  = 16'h4000;
  localparam logic [15:0] ADDR_SND_LAST  = 16'h4013;
  localparam logic [15:0] ADDR_DMA_PAGE  = 16'h4014;
  localparam logic [15:0] ADDR_SND_STAT  = 16'h4015;
  localparam logic [15:0] ADDR_PAD1      = 16'h4016;
  localparam logic [15:0] ADDR_SND_FRAME = 16'h4017;
  localparam logic [15:0] ADDR_CART_BASE = 16'h4020;

  // Largest work RAM window; RAM addresses always fit in this many bits.
  localparam int RAM_WIN_BYTES = 8192;
  localparam int RAM_WIN_W     = 13;

  // One result beat.
  typedef struct packed {
    target_t     target;
    logic [7:0]  read_data;
    fwd_t        forward;
    logic [15:0] fwd_addr;
    logic [7:0]  fwd_data;
    logic        write_ok;
    logic        oam_we;
    logic [7:0]  oam_index;
    logic [7:0]  oam_data;
    logic        cpu_enable;
    logic        dma_active;
  } result_t;

  function automatic target_t decode_target(input logic [15:0] a);
    target_t t;
    if (a < ADDR_PIC_BASE) begin
      t = TGT_RAM;
    end else if (a < ADDR_SND_BASE) begin
      t = TGT_PIC;
    end else if (a == ADDR_DMA_PAGE) begin
      t = TGT_DMA;
    end else if (a <= ADDR_SND_LAST || a == ADDR_SND_STAT || a == ADDR_SND_FRAME) begin
      t = TGT_SND;
    end else if (a == ADDR_PAD1) begin
      t = TGT_PAD;
    end else if (a >= ADDR_CART_BASE) begin
      t = TGT_CART;
    end else begin
      t = TGT_NONE;
    end
    return t;
  endfunction

  function automatic logic is_forwarded(input target_t t);
    return (t == TGT_PIC) || (t == TGT_SND) || (t == TGT_CART);
  endfunction

endpackage

/* src/cbd_if.sv */
// Valid/ready channel interfaces for the input items and the result beats.
interface cbd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] addr;
  logic [7:0]  wdata;
  logic [7:0]  pad_buttons;
  logic [7:0]  ext_data;

  modport source(output valid, cmd, addr, wdata, pad_buttons, ext_data, input ready);
  modport sink(input valid, cmd, addr, wdata, pad_buttons, ext_data, output ready);
endinterface

interface cbd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [7:0]  read_data;
  logic [1:0]  forward;
  logic [15:0] fwd_addr;
  logic [7:0]  fwd_data;
  logic        write_ok;
  logic        oam_we;
  logic [7:0]  oam_index;
  logic [7:0]  oam_data;
  logic        cpu_enable;
  logic        dma_active;

  modport source(output valid, target, read_data, forward, fwd_addr, fwd_data, write_ok,
                 oam_we, oam_index, oam_data, cpu_enable, dma_active, input ready);
  modport sink(input valid, target, read_data, forward, fwd_addr, fwd_data, write_ok,
               oam_we, oam_index, oam_data, cpu_enable, dma_active, output ready);
endinterface

/* src/cbd_ram.sv */
// Single-port synchronous work RAM with registered read data.
module cbd_ram #(
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/cpu_bus_decoder_oam_dma_core.sv */
// Top level of the processor bus decoder with work RAM, pad port and sprite DMA.
//
// The block takes one beat per clock while ready is high: a master clock tick, a
// processor read or a processor write. Each beat makes exactly one result beat,
// which passes through stage one and the output stage; when the result side is
// ready, the sustained rate is one beat per cycle. That rate is set by the work
// RAM: a single-port synchronous memory with registered read data, and every beat
// makes at most one access to it. All architectural state (pad shift register,
// DMA page, index, latch and the clock phase) is updated at the edge where a beat
// is accepted, so a write is visible to the very next beat. RAM read data joins
// the result one stage later; a DMA read step that hits RAM feeds its byte forward
// to a write step that follows at once. A registered output stage decouples the
// result side, so a new beat is taken while a finished result still waits, as long
// as stage one is empty. After reset the block runs a clearing pass that writes
// zero to every RAM byte, one per cycle; ready stays low during that pass.
// Processor slots fall on every CPU_DIVIDE-th tick and alternate even and odd
// processor cycles, which pace the DMA sync, read and write steps.
module cpu_bus_decoder_oam_dma_core #(
  parameter int RAM_BYTES  = 2048,
  parameter int CPU_DIVIDE = 3
) (
  input logic       clk,
  input logic       rst_n,
  cbd_in_if.sink    in_bus,
  cbd_out_if.source out_bus
);
  import cbd_pkg::*;

  localparam int RAM_AW    = $clog2(RAM_BYTES);
  localparam int RED_STEPS = $clog2((RAM_WIN_BYTES + RAM_BYTES - 1) / RAM_BYTES);
  localparam int SUB_W     = (CPU_DIVIDE > 1) ? $clog2(CPU_DIVIDE) : 1;

  // Mirror a window address onto the RAM by subtracting shifted copies of its size.
  function automatic logic [RAM_AW-1:0] ram_index(input logic [RAM_WIN_W-1:0] a);
    logic [15:0] v;
    v = 16'(a);
    for (int k = RED_STEPS - 1; k >= 0; k--) begin
      if (v >= (16'(RAM_BYTES) << k)) begin
        v = v - (16'(RAM_BYTES) << k);
      end
    end
    return v[RAM_AW-1:0];
  endfunction

  // Clearing pass.
  logic              clearing_r, clearing_nxt;
  logic [RAM_AW-1:0] clr_addr_r, clr_addr_nxt;

  // Architectural state.
  logic [7:0]       pad_shift_r, pad_shift_nxt;
  logic [7:0]       dma_page_r, dma_page_nxt;
  logic [7:0]       dma_index_r, dma_index_nxt;
  logic [7:0]       dma_latch_r, dma_latch_nxt;
  logic             dma_running_r, dma_running_nxt;
  logic             dma_sync_r, dma_sync_nxt;
  logic             dma_fwd_r, dma_fwd_nxt;
  logic [SUB_W-1:0] sub_r, sub_nxt;
  logic             parity_r, parity_nxt;

  // Pipeline stage one and the output stage.
  logic    s1_valid_r;
  result_t s1_res_r, s1_res_nxt;
  logic    s1_sel_ram_r, s1_sel_ram_nxt;
  logic    s1_latch_ram_r, s1_latch_ram_nxt;
  logic    out_valid_r;
  result_t out_res_r;

  // RAM request of the beat in stage zero.
  logic              req_en, req_we;
  logic [RAM_AW-1:0] req_addr;
  logic [7:0]        req_wdata;
  logic              latch_set;
  logic [7:0]        latch_s0;

  logic              ram_en, ram_we;
  logic [RAM_AW-1:0] ram_addr;
  logic [7:0]        ram_wdata, ram_q;

  logic       in_acc, s1_adv;
  logic [7:0] latch_base;
  result_t    s1_res_fin;
  target_t    tgt;
  logic [15:0] dma_src_addr;

  assign s1_adv = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !clearing_r && (!s1_valid_r || s1_adv);
  assign in_acc = in_bus.valid && in_bus.ready;
  assign dma_src_addr = {dma_page_r, dma_index_r};

  // A RAM byte fetched by a DMA read step still sits in stage one until it leaves.
  assign latch_base = (s1_valid_r && s1_latch_ram_r) ? ram_q : dma_latch_r;

  // Decode and state update of the beat being accepted.
  always_comb begin
    s1_res_nxt = '0;
    s1_res_nxt.target = TGT_NONE;
    s1_res_nxt.forward = FWD_NONE;
    s1_sel_ram_nxt = 1'b0;
    s1_latch_ram_nxt = 1'b0;
    req_en = 1'b0;
    req_we = 1'b0;
    req_addr = '0;
    req_wdata = in_bus.wdata;
    latch_set = 1'b0;
    latch_s0 = 8'd0;
    tgt = decode_target(in_bus.addr);
    pad_shift_nxt = pad_shift_r;
    dma_page_nxt = dma_page_r;
    dma_index_nxt = dma_index_r;
    dma_running_nxt = dma_running_r;
    dma_sync_nxt = dma_sync_r;
    dma_fwd_nxt = dma_fwd_r;
    sub_nxt = sub_r;
    parity_nxt = parity_r;

    case (in_bus.cmd)
      CMD_READ: begin
        s1_res_nxt.target = tgt;
        if (is_forwarded(tgt)) begin
          s1_res_nxt.forward = FWD_READ;
          s1_res_nxt.fwd_addr = in_bus.addr;
        end else if (tgt == TGT_RAM) begin
          req_en = 1'b1;
          req_addr = ram_index(in_bus.addr[RAM_WIN_W-1:0]);
          s1_sel_ram_nxt = 1'b1;
        end else if (tgt == TGT_PAD) begin
          s1_res_nxt.read_data = {7'd0, pad_shift_r[0]};
          pad_shift_nxt = {1'b0, pad_shift_r[7:1]};
        end
      end
      CMD_WRITE: begin
        s1_res_nxt.target = tgt;
        if (tgt == TGT_RAM) begin
          req_en = 1'b1;
          req_we = 1'b1;
          req_addr = ram_index(in_bus.addr[RAM_WIN_W-1:0]);
          s1_res_nxt.write_ok = 1'b1;
        end else if (tgt == TGT_PAD) begin
          pad_shift_nxt = in_bus.pad_buttons;
          s1_res_nxt.write_ok = 1'b1;
        end else if (tgt == TGT_DMA) begin
          dma_page_nxt = in_bus.wdata;
          dma_index_nxt = 8'd0;
          dma_running_nxt = 1'b1;
        end else if (is_forwarded(tgt)) begin
          s1_res_nxt.forward = FWD_WRITE;
          s1_res_nxt.fwd_addr = in_bus.addr;
          s1_res_nxt.fwd_data = in_bus.wdata;
        end
      end
      CMD_TICK: begin
        if (sub_r == '0) begin
          if (!dma_running_r) begin
            s1_res_nxt.cpu_enable = 1'b1;
          end else if (dma_sync_r) begin
            if (parity_r) begin
              dma_sync_nxt = 1'b0;
            end
          end else if (!parity_r) begin
            // Read step.
            tgt = decode_target(dma_src_addr);
            s1_res_nxt.target = tgt;
            if (is_forwarded(tgt)) begin
              s1_res_nxt.forward = FWD_READ;
              s1_res_nxt.fwd_addr = dma_src_addr;
              dma_fwd_nxt = 1'b1;
            end else begin
              dma_fwd_nxt = 1'b0;
              latch_set = 1'b1;
              if (tgt == TGT_RAM) begin
                req_en = 1'b1;
                req_addr = ram_index(dma_src_addr[RAM_WIN_W-1:0]);
                s1_sel_ram_nxt = 1'b1;
                s1_latch_ram_nxt = 1'b1;
                latch_s0 = latch_base;
                latch_set = 1'b0;
              end else if (tgt == TGT_PAD) begin
                latch_s0 = {7'd0, pad_shift_r[0]};
                s1_res_nxt.read_data = latch_s0;
                pad_shift_nxt = {1'b0, pad_shift_r[7:1]};
              end
            end
          end else begin
            // Write step into sprite memory.
            latch_set = 1'b1;
            latch_s0 = dma_fwd_r ? in_bus.ext_data : latch_base;
            dma_fwd_nxt = 1'b0;
            s1_res_nxt.oam_we = 1'b1;
            s1_res_nxt.oam_index = dma_index_r;
            s1_res_nxt.oam_data = latch_s0;
            dma_index_nxt = dma_index_r + 8'd1;
            if (dma_index_r == 8'hFF) begin
              dma_running_nxt = 1'b0;
              dma_sync_nxt = 1'b1;
            end
          end
        end
        if (sub_r == SUB_W'(CPU_DIVIDE - 1)) begin
          sub_nxt = '0;
          parity_nxt = !parity_r;
        end else begin
          sub_nxt = sub_r + SUB_W'(1);
        end
      end
      default: begin
      end
    endcase
    s1_res_nxt.dma_active = dma_running_nxt;
  end

  assign dma_latch_nxt = (in_acc && latch_set) ? latch_s0 : latch_base;

  // RAM port: the clearing pass owns it until every byte is zero.
  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      ram_en = 1'b1;
      ram_we = 1'b1;
      ram_addr = clr_addr_r;
      ram_wdata = 8'd0;
      if (clr_addr_r == RAM_AW'(RAM_BYTES - 1)) begin
        clearing_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + RAM_AW'(1);
      end
    end else begin
      ram_en = in_acc && req_en;
      ram_we = req_we;
      ram_addr = req_addr;
      ram_wdata = req_wdata;
    end
  end

  cbd_ram #(
    .DEPTH(RAM_BYTES)
  ) u_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_q)
  );

  always_comb begin
    s1_res_fin = s1_res_r;
    if (s1_sel_ram_r) begin
      s1_res_fin.read_data = ram_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
      pad_shift_r <= 8'd0;
      dma_page_r <= 8'd0;
      dma_index_r <= 8'd0;
      dma_latch_r <= 8'd0;
      dma_running_r <= 1'b0;
      dma_sync_r <= 1'b1;
      dma_fwd_r <= 1'b0;
      sub_r <= '0;
      parity_r <= 1'b0;
      s1_valid_r <= 1'b0;
      s1_sel_ram_r <= 1'b0;
      s1_latch_ram_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_addr_r <= clr_addr_nxt;
      dma_latch_r <= dma_latch_nxt;
      if (in_acc) begin
        pad_shift_r <= pad_shift_nxt;
        dma_page_r <= dma_page_nxt;
        dma_index_r <= dma_index_nxt;
        dma_running_r <= dma_running_nxt;
        dma_sync_r <= dma_sync_nxt;
        dma_fwd_r <= dma_fwd_nxt;
        sub_r <= sub_nxt;
        parity_r <= parity_nxt;
        s1_sel_ram_r <= s1_sel_ram_nxt;
        s1_latch_ram_r <= s1_latch_ram_nxt;
      end else if (s1_adv) begin
        s1_latch_ram_r <= 1'b0;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_res_r <= s1_res_nxt;
    end
    if (s1_adv) begin
      out_res_r <= s1_res_fin;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.target     = out_res_r.target;
  assign out_bus.read_data  = out_res_r.read_data;
  assign out_bus.forward    = out_res_r.forward;
  assign out_bus.fwd_addr   = out_res_r.fwd_addr;
  assign out_bus.fwd_data   = out_res_r.fwd_data;
  assign out_bus.write_ok   = out_res_r.write_ok;
  assign out_bus.oam_we     = out_res_r.oam_we;
  assign out_bus.oam_index  = out_res_r.oam_index;
  assign out_bus.oam_data   = out_res_r.oam_data;
  assign out_bus.cpu_enable = out_res_r.cpu_enable;
  assign out_bus.dma_active = out_res_r.dma_active;

  // No beat may share the RAM port with the clearing pass.
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    !(clearing_r && in_bus.valid && in_bus.ready))
    else $error("beat accepted during RAM clearing pass");

  // Every sprite memory write advances the DMA index by one.
  a_index_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && s1_res_nxt.oam_we) |=> (dma_index_r == $past(dma_index_r) + 8'd1))
    else $error("DMA index did not advance on a sprite write");

  // Sync completes only on an odd processor slot.
  a_sync_on_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (dma_running_r && $fell(dma_sync_r)) |-> $past(parity_r))
    else $error("DMA sync finished on an even processor cycle");

  // A granted processor cycle never carries DMA traffic.
  a_grant_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.cpu_enable) |->
      (!out_res_r.oam_we && out_res_r.forward == FWD_NONE))
    else $error("processor grant together with DMA traffic");

endmodule
